// ----- hw/rtl/sphere_cone_intersection_unit_assert.svh -----
// Assertion macros for the top-level RTL file. Each expects clk and rst_n in scope.
`ifndef SPHERE_CONE_INTERSECTION_UNIT_ASSERT_SVH
`define SPHERE_CONE_INTERSECTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sci_pkg.sv -----
`default_nettype none

package sci_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TRIG_BITS    = 30;

    localparam int CORDIC_W = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032875;
    localparam logic [30:0] HALF_PI_M1 = 31'd1686629712;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Divider: 63-bit dividend, 31-bit divisor, 32 quotient bits plus an overflow check.
    localparam int NUM_W   = 63;
    localparam int DEN_W   = 31;
    localparam int QUO_W   = 32;
    localparam int DIV_LAT = QUO_W + 1;

    // Square root: 64-bit radicand, 32-bit root, one root bit per stage.
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = 34;
    localparam int SQRT_LAT = ROOT_W;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] r;
        case (idx)
            5'd0:  r = 31'd843314857;
            5'd1:  r = 31'd497837829;
            5'd2:  r = 31'd263043837;
            5'd3:  r = 31'd133525159;
            5'd4:  r = 31'd67021688;
            5'd5:  r = 31'd33543516;
            5'd6:  r = 31'd16775851;
            5'd7:  r = 31'd8388437;
            5'd8:  r = 31'd4194283;
            5'd9:  r = 31'd2097149;
            5'd10: r = 31'd1048576;
            5'd11: r = 31'd524288;
            5'd12: r = 31'd262144;
            5'd13: r = 31'd131072;
            5'd14: r = 31'd65536;
            5'd15: r = 31'd32768;
            5'd16: r = 31'd16384;
            5'd17: r = 31'd8192;
            5'd18: r = 31'd4096;
            5'd19: r = 31'd2048;
            5'd20: r = 31'd1024;
            5'd21: r = 31'd512;
            5'd22: r = 31'd256;
            5'd23: r = 31'd128;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sci_cordic.sv -----
`default_nettype none

// Unrolled CORDIC rotator, one rotation step per register stage.
module sci_cordic (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] angle,
    output logic      [30:0] cos_out,
    output logic      [30:0] sin_out
);

    localparam int STEPS = sci_pkg::CORDIC_STEPS;
    localparam int CW    = sci_pkg::CORDIC_W;

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [CW-1:0] z_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [CW-1:0] x_in, y_in, z_in;
        logic signed [CW-1:0] x_next, y_next, z_next;
        logic signed [CW-1:0] at;

        if (i == 0) begin : g_first
            assign x_in = sci_pkg::CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = $signed({2'b00, angle});
        end else begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
        end

        assign at = $signed({2'b00, sci_pkg::atan_q30(5'(i))});

        always_comb
        begin
            if (!z_in[CW-1])
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - at;
            end
            else
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    logic signed [CW-1:0] x_last, y_last, one_s;

    assign x_last = x_reg[STEPS-1];
    assign y_last = y_reg[STEPS-1];
    assign one_s  = $signed({2'b00, sci_pkg::ONE_Q30});

    // Cosine is kept at least one LSB so that the later quotient stays defined.
    always_comb
    begin
        if (x_last < 1)
            cos_out = 31'd1;
        else if (x_last > one_s)
            cos_out = sci_pkg::ONE_Q30;
        else
            cos_out = x_last[30:0];

        if (y_last[CW-1])
            sin_out = '0;
        else if (y_last > one_s)
            sin_out = sci_pkg::ONE_Q30;
        else
            sin_out = y_last[30:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sci_div.sv -----
`default_nettype none

// Pipelined restoring divider with an up-front overflow check.
module sci_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [sci_pkg::NUM_W-1:0]     num,
    input  wire logic [sci_pkg::DEN_W-1:0]     den,
    output logic      [sci_pkg::QUO_W-1:0]     quo,
    output logic                               ovf
);

    localparam int QW = sci_pkg::QUO_W;
    localparam int DW = sci_pkg::DEN_W;
    localparam int NW = sci_pkg::NUM_W;

    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] lo_reg  [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic          ovf_reg [QW+1];

    // The quotient fits in QW bits only when the upper dividend part is below the divisor.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NW-1:QW];
            lo_reg[0]  <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= (num[NW-1:QW] >= den);
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_bit
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], lo_reg[k-1][QW-1]};
            ge       = (trial >= {1'b0, den_reg[k-1]});
            rem_next = ge ? DW'(trial - {1'b0, den_reg[k-1]}) : trial[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                lo_reg[k]  <= {lo_reg[k-1][QW-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

`default_nettype wire

// ----- hw/rtl/sci_sqrt.sv -----
`default_nettype none

// Pipelined digit-by-digit integer square root, one root bit per stage.
module sci_sqrt (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [sci_pkg::RAD_W-1:0]    rad,
    output logic      [sci_pkg::ROOT_W-1:0]   root
);

    localparam int RW = sci_pkg::ROOT_W;
    localparam int NW = sci_pkg::RAD_W;
    localparam int MW = sci_pkg::REM_W;

    logic [MW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [NW-1:0] n_reg    [RW];

    for (genvar k = 0; k < RW; k++) begin : g_bit
        logic [MW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [NW-1:0] n_in;
        logic [MW+1:0] cur;
        logic [MW+1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = rad;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign n_in    = n_reg[k-1];
        end

        always_comb
        begin
            cur   = {rem_in, n_in[NW-1:NW-2]};
            trial = (MW+2)'({root_in, 2'b01});
            ge    = (cur >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? MW'(cur - trial) : cur[MW-1:0];
                root_reg[k] <= {root_in[RW-2:0], ge};
                n_reg[k]    <= {n_in[NW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

`default_nettype wire

// ----- hw/rtl/sphere_cone_intersection_unit.sv -----
// Sphere versus capped cone intersection test.
// The sphere centre and radius are written through the APB-style port (registers
// sphere_x, sphere_y, sphere_z and sphere_radius at byte addresses 0, 4, 8 and 12);
// they are to be written only while no transfer is in flight, which the block itself
// does not enforce. Each input transfer carries one cone (tip, unit axis, height, full
// opening angle) and produces exactly one output transfer whose intersects bit is set
// when the sphere meets the cone. The datapath is one pipeline whose length is set by
// the CORDIC rotator and the bit-per-stage divider that forms the cone slope term. One
// transfer is accepted every cycle while the receiver does not stall the output, so
// throughput is one cone per clock. When the receiver stalls with a result waiting in
// the output register, the whole pipeline holds and in_ready falls in the same cycle;
// nothing is dropped or repeated, and the pipeline resumes as soon as out_ready rises
// again. Reset clears the configuration registers to zero and empties the pipeline.
// Positions, height and radius are Q16.16; the axis and the angle carry 16 fraction
// bits in 18 bits; trigonometric values are Q2.30 inside the pipeline.
`default_nettype none

`include "sphere_cone_intersection_unit_assert.svh"

module sphere_cone_intersection_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] tip_x,
    input  wire logic signed [31:0] tip_y,
    input  wire logic signed [31:0] tip_z,
    input  wire logic signed [17:0] dir_x,
    input  wire logic signed [17:0] dir_y,
    input  wire logic signed [17:0] dir_z,
    input  wire logic [30:0]        cone_height,
    input  wire logic [17:0]        cone_angle,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    intersects
);

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_SPHERE_X      = 2'd0;
    localparam logic [1:0] REG_SPHERE_Y      = 2'd1;
    localparam logic [1:0] REG_SPHERE_Z      = 2'd2;
    localparam logic [1:0] REG_SPHERE_RADIUS = 2'd3;

    localparam int FRAC  = sci_pkg::FRAC_BITS;
    localparam int TRIG  = sci_pkg::TRIG_BITS;
    localparam int STEPS = sci_pkg::CORDIC_STEPS;

    // Stage numbering: S1 is the first register after the input transfer.
    localparam int S_T  = 1 + STEPS;                 // sine and cosine available
    localparam int S_P  = S_T + 1;                   // slope product registered
    localparam int S_Q  = S_P + sci_pkg::DIV_LAT;    // quotient available
    localparam int N    = S_Q + 4;                   // output register
    localparam int D_MN = S_T - 5;                   // axial magnitude delay, S6..S_T
    localparam int D_C  = S_Q + 1 - (6 + sci_pkg::SQRT_LAT);  // root delay up to S_Q+1

    localparam int DOT_W = 52;
    localparam int A_W   = DOT_W - FRAC;
    localparam int CMP_W = DOT_W + 4;
    localparam int ANG_W = 40;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] sphere_x_reg, sphere_y_reg, sphere_z_reg;
    logic        [30:0] sphere_radius_reg;
    logic               cfg_write;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere_x_reg      <= '0;
            sphere_y_reg      <= '0;
            sphere_z_reg      <= '0;
            sphere_radius_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SPHERE_X:      sphere_x_reg      <= pwdata;
                REG_SPHERE_Y:      sphere_y_reg      <= pwdata;
                REG_SPHERE_Z:      sphere_z_reg      <= pwdata;
                REG_SPHERE_RADIUS: sphere_radius_reg <= pwdata[30:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SPHERE_X:      prdata = sphere_x_reg;
            REG_SPHERE_Y:      prdata = sphere_y_reg;
            REG_SPHERE_Z:      prdata = sphere_z_reg;
            REG_SPHERE_RADIUS: prdata = {1'b0, sphere_radius_reg};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipeline advances together; it holds only
    // when a result sits in the output register and the receiver is not ready.
    // ------------------------------------------------------------------
    logic [N:1] valid_reg;
    logic       adv;
    logic       in_xfer;

    assign adv       = !valid_reg[N] || out_ready;
    assign in_ready  = adv;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = valid_reg[N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[N-1:1], in_xfer};
    end

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] p,
                                                   input logic signed [31:0] q);
        logic signed [32:0] s;
        s = 33'(p) - 33'(q);
        if (s[32] != s[31])
            return s[32] ? sci_pkg::S32_MIN : sci_pkg::S32_MAX;
        return s[31:0];
    endfunction

    // ------------------------------------------------------------------
    // S1: centre minus tip with saturation, half angle clamped below pi/2.
    // ------------------------------------------------------------------
    logic signed [31:0] v_x_reg, v_y_reg, v_z_reg;
    logic signed [17:0] d_x_reg, d_y_reg, d_z_reg;
    logic        [30:0] height1_reg;
    logic        [30:0] half_reg;
    logic [ANG_W-1:0]   ang_sh;

    assign ang_sh = ANG_W'(cone_angle) << (TRIG - 1 - FRAC);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_x_reg     <= sat_sub(sphere_x_reg, tip_x);
            v_y_reg     <= sat_sub(sphere_y_reg, tip_y);
            v_z_reg     <= sat_sub(sphere_z_reg, tip_z);
            d_x_reg     <= dir_x;
            d_y_reg     <= dir_y;
            d_z_reg     <= dir_z;
            height1_reg <= cone_height;
            half_reg    <= (ang_sh > ANG_W'(sci_pkg::HALF_PI_M1)) ? sci_pkg::HALF_PI_M1
                                                                   : ang_sh[30:0];
        end
    end

    // ------------------------------------------------------------------
    // S2: products for the axial dot product and the squared length.
    // ------------------------------------------------------------------
    logic signed [49:0] p_x_reg, p_y_reg, p_z_reg;
    logic        [63:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic        [30:0] height2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_x_reg     <= 50'(v_x_reg) * 50'(d_x_reg);
            p_y_reg     <= 50'(v_y_reg) * 50'(d_y_reg);
            p_z_reg     <= 50'(v_z_reg) * 50'(d_z_reg);
            sq_x_reg    <= 64'(v_x_reg) * 64'(v_x_reg);
            sq_y_reg    <= 64'(v_y_reg) * 64'(v_y_reg);
            sq_z_reg    <= 64'(v_z_reg) * 64'(v_z_reg);
            height2_reg <= height1_reg;
        end
    end

    // ------------------------------------------------------------------
    // S3: axial distance a (arithmetic shift of the dot product) and |v|^2.
    // ------------------------------------------------------------------
    logic signed [DOT_W-1:0] dot;
    logic signed [A_W-1:0]   a_full_reg;
    logic        [63:0]      vv3_reg;
    logic        [30:0]      height3_reg;

    assign dot = DOT_W'(p_x_reg) + DOT_W'(p_y_reg) + DOT_W'(p_z_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_full_reg  <= dot[DOT_W-1:FRAC];
            vv3_reg     <= sq_x_reg + sq_y_reg + sq_z_reg;
            height3_reg <= height2_reg;
        end
    end

    // ------------------------------------------------------------------
    // S4: early reject against height plus radius, then saturate a.
    // ------------------------------------------------------------------
    logic signed [CMP_W-1:0] a_ext, lim_ext;
    logic                    reject4_reg;
    logic signed [31:0]      a_sat_reg;
    logic        [63:0]      vv4_reg;
    logic signed [31:0]      a_sat;

    assign a_ext   = CMP_W'(a_full_reg);
    assign lim_ext = $signed(CMP_W'({1'b0, height3_reg} + {1'b0, sphere_radius_reg}));

    always_comb
    begin
        if (a_ext > CMP_W'(sci_pkg::S32_MAX))
            a_sat = sci_pkg::S32_MAX;
        else if (a_ext < CMP_W'(sci_pkg::S32_MIN))
            a_sat = sci_pkg::S32_MIN;
        else
            a_sat = a_ext[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            reject4_reg <= (a_ext > lim_ext);
            a_sat_reg   <= a_sat;
            vv4_reg     <= vv3_reg;
        end
    end

    // ------------------------------------------------------------------
    // S5: a squared and |a|, S6: radicand clamped at zero.
    // ------------------------------------------------------------------
    logic [63:0] aa5_reg, vv5_reg, diff_reg;
    logic [31:0] mag5_reg;
    logic        neg5_reg, reject5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aa5_reg     <= 64'(a_sat_reg) * 64'(a_sat_reg);
            mag5_reg    <= a_sat_reg[31] ? (~a_sat_reg + 32'd1) : a_sat_reg;
            neg5_reg    <= a_sat_reg[31];
            reject5_reg <= reject4_reg;
            vv5_reg     <= vv4_reg;
            diff_reg    <= (aa5_reg > vv5_reg) ? 64'd0 : (vv5_reg - aa5_reg);
        end
    end

    // ------------------------------------------------------------------
    // Half-angle sine and cosine, running alongside from S1 up to S_T.
    // ------------------------------------------------------------------
    logic [30:0] cos_w, sin_w;

    sci_cordic u_cordic (
        .clk     (clk),
        .en      (adv),
        .angle   (half_reg),
        .cos_out (cos_w),
        .sin_out (sin_w)
    );

    // Square root of the radicand, S7 to S6 + SQRT_LAT.
    logic [sci_pkg::ROOT_W-1:0] root_w;

    sci_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (diff_reg),
        .root (root_w)
    );

    // Delay |a| and its flags from S6 to S_T to meet the CORDIC result.
    logic [31:0] mag_dly_reg    [D_MN];
    logic        neg_dly_reg    [D_MN];
    logic        reject_dly_reg [D_MN];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_dly_reg[0]    <= mag5_reg;
            neg_dly_reg[0]    <= neg5_reg;
            reject_dly_reg[0] <= reject5_reg;
            for (int k = 1; k < D_MN; k++)
            begin
                mag_dly_reg[k]    <= mag_dly_reg[k-1];
                neg_dly_reg[k]    <= neg_dly_reg[k-1];
                reject_dly_reg[k] <= reject_dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // S_P: |a| * sin, then the divider forms |a| * sin / cos.
    // ------------------------------------------------------------------
    logic [sci_pkg::NUM_W-1:0] prod_reg;
    logic [30:0]               cos_p_reg;
    logic                      neg_p_reg, reject_p_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg     <= sci_pkg::NUM_W'(mag_dly_reg[D_MN-1]) * sci_pkg::NUM_W'(sin_w);
            cos_p_reg    <= cos_w;
            neg_p_reg    <= neg_dly_reg[D_MN-1];
            reject_p_reg <= reject_dly_reg[D_MN-1];
        end
    end

    logic [sci_pkg::QUO_W-1:0] quo_w;
    logic                      ovf_w;

    sci_div u_div (
        .clk (clk),
        .en  (adv),
        .num (prod_reg),
        .den (cos_p_reg),
        .quo (quo_w),
        .ovf (ovf_w)
    );

    localparam int DL = sci_pkg::DIV_LAT;

    logic [30:0] cos_q_reg    [DL];
    logic        neg_q_reg    [DL];
    logic        reject_q_reg [DL];
    logic [sci_pkg::ROOT_W-1:0] root_dly_reg [D_C];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_q_reg[0]    <= cos_p_reg;
            neg_q_reg[0]    <= neg_p_reg;
            reject_q_reg[0] <= reject_p_reg;
            for (int k = 1; k < DL; k++)
            begin
                cos_q_reg[k]    <= cos_q_reg[k-1];
                neg_q_reg[k]    <= neg_q_reg[k-1];
                reject_q_reg[k] <= reject_q_reg[k-1];
            end
            root_dly_reg[0] <= root_w;
            for (int k = 1; k < D_C; k++)
                root_dly_reg[k] <= root_dly_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // S_Q+1: signed, saturated b. S_Q+2: d = c - b. S_Q+3: d * cos.
    // S_Q+4: the output register holds the verdict.
    // ------------------------------------------------------------------
    logic signed [31:0] b_reg;
    logic signed [31:0] b_val;
    logic        [30:0] cos_b_reg, cos_d_reg;
    logic               reject_b_reg, reject_d_reg, reject_f_reg;
    logic signed [33:0] d_reg;
    logic        [63:0] prod2_reg;
    logic               dneg_reg, dzero_reg;
    logic               hit_reg;
    logic               hit_next;

    always_comb
    begin
        if (neg_q_reg[DL-1])
        begin
            if (ovf_w || (quo_w > 32'h8000_0000))
                b_val = sci_pkg::S32_MIN;
            else
                b_val = ~quo_w + 32'd1;
        end
        else
        begin
            if (ovf_w || quo_w[31])
                b_val = sci_pkg::S32_MAX;
            else
                b_val = quo_w;
        end
    end

    always_comb
    begin
        if (reject_f_reg)
            hit_next = 1'b0;
        else if (dneg_reg)
            hit_next = 1'b1;
        else if (dzero_reg)
            hit_next = (sphere_radius_reg != '0);
        else
            hit_next = (prod2_reg[63:TRIG] < (64 - TRIG)'(sphere_radius_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg        <= b_val;
            cos_b_reg    <= cos_q_reg[DL-1];
            reject_b_reg <= reject_q_reg[DL-1];

            d_reg        <= $signed({2'b00, root_dly_reg[D_C-1]}) - 34'(b_reg);
            cos_d_reg    <= cos_b_reg;
            reject_d_reg <= reject_b_reg;

            prod2_reg    <= 64'(d_reg[32:0]) * 64'(cos_d_reg);
            dneg_reg     <= d_reg[33];
            dzero_reg    <= (d_reg == '0);
            reject_f_reg <= reject_d_reg;

            hit_reg      <= hit_next;
        end
    end

    assign intersects = hit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic trig_ok;
    logic reject_out;

    assign trig_ok    = (cos_w != '0) && (sin_w <= sci_pkg::ONE_Q30);
    assign reject_out = valid_reg[N-1] && reject_f_reg && adv;

    `SCI_ASSERT_NEXT(a_entry_valid, in_xfer, valid_reg[1], "accepted transfer was lost")
    `SCI_ASSERT_NOW(a_trig_range, valid_reg[S_T], trig_ok, "sine or cosine out of range")
    `SCI_ASSERT_NEXT(a_reject_miss, reject_out, !intersects, "rejected cone reported as hit")

endmodule

`default_nettype wire

// ----- dv/sphere_cone_intersection_unit_tb.sv -----
`default_nettype none

module sphere_cone_intersection_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register byte addresses on the configuration port.
    localparam logic [3:0] REG_SPHERE_X      = 4'd0;
    localparam logic [3:0] REG_SPHERE_Y      = 4'd4;
    localparam logic [3:0] REG_SPHERE_Z      = 4'd8;
    localparam logic [3:0] REG_SPHERE_RADIUS = 4'd12;

    // The settle margin is taken with room to spare over the pipeline depth.
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int PHASES        = 6;

    // Arctangent of 2^-i in Q2.30, used by the rotator in the predictor.
    localparam longint ARC_TAB [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021688, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };
    localparam longint ROT_GAIN    = 652032875;
    localparam longint HALF_ANG_MAX = 1686629712;
    localparam longint UNIT_Q30    = 64'd1 << 30;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [17:0] az;
        logic [30:0]        height;
        logic [17:0]        angle;
    } cone_t;

    // The scoreboard keeps its own copy of the sphere registers and a queue of
    // predicted hit flags, one per accepted cone, in transfer order.
    class cone_scoreboard;
        longint sx, sy, sz, srad;
        bit     hit_q[$];
        int     errors;

        function new();
            sx = 0;
            sy = 0;
            sz = 0;
            srad = 0;
            errors = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned root64(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function void set_reg(logic [3:0] addr, logic [31:0] value);
            case (addr)
                REG_SPHERE_X:      sx = longint'($signed(value));
                REG_SPHERE_Y:      sy = longint'($signed(value));
                REG_SPHERE_Z:      sz = longint'($signed(value));
                REG_SPHERE_RADIUS: srad = longint'(value[30:0]);
                default: ;
            endcase
        endfunction

        function bit predict_hit(cone_t c);
            longint vx, vy, vz, ax, ay, az, a, half, xr, yr, zr, sx_r, sy_r, b, d;
            longint unsigned mag, q, vv, aa, diff, root, e;
            vx = clamp32(sx - longint'(c.tx));
            vy = clamp32(sy - longint'(c.ty));
            vz = clamp32(sz - longint'(c.tz));
            ax = longint'(c.ax);
            ay = longint'(c.ay);
            az = longint'(c.az);
            a = (vx * ax + vy * ay + vz * az) >>> 16;
            // Early reject on the unsaturated axial distance.
            if (a > longint'(c.height) + srad)
                return 1'b0;
            a = clamp32(a);
            half = longint'(c.angle) << 13;
            if (half > HALF_ANG_MAX)
                half = HALF_ANG_MAX;
            xr = ROT_GAIN;
            yr = 0;
            zr = half;
            for (int i = 0; i < sci_pkg::CORDIC_STEPS; i++)
            begin
                sx_r = yr >>> i;
                sy_r = xr >>> i;
                if (zr >= 0)
                begin
                    xr = xr - sx_r;
                    yr = yr + sy_r;
                    zr = zr - ARC_TAB[i];
                end
                else
                begin
                    xr = xr + sx_r;
                    yr = yr - sy_r;
                    zr = zr + ARC_TAB[i];
                end
            end
            if (yr < 0)
                yr = 0;
            if (yr > UNIT_Q30)
                yr = UNIT_Q30;
            if (xr < 1)
                xr = 1;
            if (xr > UNIT_Q30)
                xr = UNIT_Q30;
            mag = longint'(a < 0 ? -a : a);
            q = mag * longint'(yr) / longint'(xr);
            if (a >= 0)
                b = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
            else
                b = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
            vv = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
            aa = longint'(a * a);
            diff = (aa > vv) ? 64'd0 : vv - aa;
            root = root64(diff);
            d = longint'(root) - b;
            if (d < 0)
                return 1'b1;
            if (d == 0)
                return srad > 0;
            e = (longint'(d) * longint'(xr)) >> 30;
            return e < longint'(srad);
        endfunction

        function void note_cone(cone_t c);
            hit_q.push_back(predict_hit(c));
        endfunction

        function void check_result(bit actual);
            bit want;
            if (hit_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual intersects=%0b",
                         $realtime, actual);
                errors++;
                return;
            end
            want = hit_q.pop_front();
            if (want !== actual)
            begin
                $display("%0t: intersects mismatch, expected %0b, actual %0b",
                         $realtime, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] tip_x = '0;
    logic signed [31:0] tip_y = '0;
    logic signed [31:0] tip_z = '0;
    logic signed [17:0] dir_x = '0;
    logic signed [17:0] dir_y = '0;
    logic signed [17:0] dir_z = '0;
    logic [30:0]        cone_height = '0;
    logic [17:0]        cone_angle = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               intersects;

    cone_scoreboard sb = new();
    int unsigned    cyc = 0;

    sphere_cone_intersection_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tip_x       (tip_x),
        .tip_y       (tip_y),
        .tip_z       (tip_z),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .cone_height (cone_height),
        .cone_angle  (cone_angle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .intersects  (intersects)
    );

    always #5 clk = ~clk;

    // Both channels are observed at the same edge. Every transfer is sampled from
    // the values that stood before the edge, so event order within the step does
    // not matter; a cone's result cannot emerge in the cycle it was accepted.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n && in_valid && in_ready)
            sb.note_cone('{tip_x, tip_y, tip_z, dir_x, dir_y, dir_z, cone_height, cone_angle});
        if (rst_n && out_valid && out_ready)
            sb.check_result(intersects);
    end

    // The receiver cycles through four stall behaviours, switching as cyc[9:8] changes:
    // always ready, occasional stalls, mostly stalled, and a short fixed pattern.
    always @(posedge clk)
    begin
        case (cyc[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= (cyc[2:0] != 3'd5) && (cyc[2:0] != 3'd6);
        endcase
    end

    // Setup cycle then access cycle; the register takes the value at the edge that
    // ends the access cycle, which is when the local copy is updated too.
    task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(addr, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_sphere(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [30:0] r);
        write_reg(REG_SPHERE_X, x);
        write_reg(REG_SPHERE_Y, y);
        write_reg(REG_SPHERE_Z, z);
        write_reg(REG_SPHERE_RADIUS, {1'b0, r});
        @(posedge clk);
    endtask

    // Called just after a rising edge. Valid goes up with the payload and is held
    // until the transfer; in_ready is looked at on the falling edge, when it has
    // settled, and the following rising edge is the one that accepts the cone.
    task automatic push_cone(input cone_t c);
        in_valid <= 1'b1;
        tip_x <= c.tx;
        tip_y <= c.ty;
        tip_z <= c.tz;
        dir_x <= c.ax;
        dir_y <= c.ay;
        dir_z <= c.az;
        cone_height <= c.height;
        cone_angle <= c.angle;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Wait for every outstanding result, then let the pipeline settle.
    task automatic drain();
        hold_off(1);
        while (sb.hit_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic cone_t make_cone(input longint px, input longint py, input longint pz,
                                        input int ax, input int ay, input int az,
                                        input longint h, input int ang);
        cone_t c;
        c.tx = px[31:0];
        c.ty = py[31:0];
        c.tz = pz[31:0];
        c.ax = ax[17:0];
        c.ay = ay[17:0];
        c.az = az[17:0];
        c.height = h[30:0];
        c.angle = ang[17:0];
        return c;
    endfunction

    // A cone placed around the sphere: tip within a few radii of the centre, axis
    // roughly unit length, so that hits and misses both occur in large numbers.
    function automatic cone_t cone_near_sphere();
        cone_t c;
        real   rx, ry, rz, len;
        longint spread;
        spread = (sb.srad > 0 ? sb.srad * 4 : 64'd1 << 18) + 1;
        if (spread > 64'd1 << 30)
            spread = 64'd1 << 30;
        rx = real'($urandom_range(0, 2000)) - 1000.0;
        ry = real'($urandom_range(0, 2000)) - 1000.0;
        rz = real'($urandom_range(0, 2000)) - 1000.0;
        len = $sqrt(rx * rx + ry * ry + rz * rz);
        if (len < 1.0)
        begin
            rx = 1.0;
            len = 1.0;
        end
        c = make_cone(
            sb.sx + longint'($urandom_range(0, 32'(2 * spread))) - spread,
            sb.sy + longint'($urandom_range(0, 32'(2 * spread))) - spread,
            sb.sz + longint'($urandom_range(0, 32'(2 * spread))) - spread,
            int'(rx / len * 65536.0), int'(ry / len * 65536.0), int'(rz / len * 65536.0),
            longint'($urandom_range(0, 32'(6 * spread))), $urandom_range(0, 205000));
        // Now and then snap to an exact axis at full scale.
        if ($urandom_range(0, 7) == 0)
        begin
            c.ax = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
            c.ay = '0;
            c.az = '0;
        end
        // Tip overflow of the centre copy is fine: the wrap lands somewhere legal.
        return c;
    endfunction

    // Unstructured cones: tip and height over their whole width, axis and angle at times too.
    function automatic cone_t cone_noise();
        cone_t c;
        c.tx = $urandom;
        c.ty = $urandom;
        c.tz = $urandom;
        c.ax = $urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 131072) - 65536);
        c.ay = $urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 131072) - 65536);
        c.az = $urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 131072) - 65536);
        c.height = 31'($urandom);
        c.angle = $urandom_range(0, 3) == 0 ? 18'($urandom) : 18'($urandom_range(0, 205000));
        return c;
    endfunction

    // Runs one stretch of random cones in bursts, with random gaps between them;
    // some stretches keep the sender busy with no gaps at all.
    task automatic random_cones(input int count);
        int sent;
        int burst;
        bit no_gaps;
        sent = 0;
        no_gaps = ($urandom_range(0, 2) == 0);
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                push_cone($urandom_range(0, 5) == 0 ? cone_noise() : cone_near_sphere());
                sent++;
            end
            if (!no_gaps)
                hold_off($urandom_range(0, 6));
        end
    endtask

    initial
    begin
        logic [31:0] px, py, pz;
        logic [30:0] pr;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cones with the registers still at their reset values.
        push_cone(make_cone(0, 0, 0, 65536, 0, 0, 0, 0));               // all zero, radius zero
        push_cone(make_cone(0, 0, 0, 0, 65536, 0, 65536, 205000));      // widest legal angle
        push_cone(make_cone(0, 0, 0, 0, 0, 65536, 65536, 262143));      // angle past pi, clamped
        push_cone(make_cone(64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF,
                            -65536, 65536, -65536, 64'h7FFFFFFF, 131072)); // saturating v
        push_cone(make_cone(-64'sh80000000, 64'sh7FFFFFFF, -64'sh80000000,
                            65536, 65536, 65536, 0, 100));
        push_cone(make_cone(-64'sh80000000, 0, 0, -65536, 0, 0, 0, 1000)); // sphere behind tip, on axis
        push_cone(make_cone(0, 0, 0, 131071, -131072, 70000, 5, 50000));  // non-unit axis
        drain();

        write_sphere(32'h0010_0000, 32'hFFF0_0000, 32'h0, 31'h0002_0000);
        push_cone(make_cone(0, -64'sh100000, 0, 65536, 0, 0, 64'h100000, 65536));   // centre on the cap
        push_cone(make_cone(0, -64'sh100000, 0, 65536, 0, 0, 64'hE0000, 0));        // short axis
        push_cone(make_cone(64'h100000, -64'sh100000, 0, 0, 0, 65536, 0, 0));       // tip at centre
        push_cone(make_cone(64'h140000, -64'sh100000, 0, -65536, 0, 0, 64'h10000, 0)); // reject
        push_cone(make_cone(64'h100000, -64'sh140000, 0, 0, 65536, 0, 64'h80000, 205000));
        push_cone(make_cone(64'h100000, -64'sh100000, -64'sh30000, 0, 0, 65536, 64'h10000, 1));
        push_cone(make_cone(64'h100000, -64'sh100000, 64'sh30000, 0, 0, 65536, 64'h7FFFFFFF,
                            205000));                                       // negative axial
        push_cone(make_cone(0, 0, 0, 46341, -46341, 0, 64'h200000, 20000));
        drain();

        // Random phases, each under a different sphere; the first and second use
        // the register extremes, the rest random centres and radii.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin px = 32'h7FFF_FFFF; py = 32'h8000_0000; pz = 32'h0;
                         pr = 31'h7FFF_FFFF; end
                1: begin px = 32'h8000_0000; py = 32'h7FFF_FFFF; pz = 32'h8000_0000;
                         pr = 31'h0; end
                default: begin
                    px = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 22)) - (1 << 21);
                    py = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 22)) - (1 << 21);
                    pz = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 22)) - (1 << 21);
                    pr = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 1 << 20));
                end
            endcase
            write_sphere(px, py, pz, pr);
            random_cones(RANDOM_ITEMS / (2 * PHASES));
            // Let the sender stand still until the pipeline has emptied out.
            while (sb.hit_q.size() != 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            random_cones(RANDOM_ITEMS / (2 * PHASES));
            drain();
        end

        if (sb.errors == 0)
            $display("PASS sphere_cone_intersection_unit");
        else
            $display("FAIL sphere_cone_intersection_unit");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL sphere_cone_intersection_unit");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sci_pkg.sv
hw/rtl/sci_cordic.sv
hw/rtl/sci_div.sv
hw/rtl/sci_sqrt.sv
hw/rtl/sphere_cone_intersection_unit.sv
dv/sphere_cone_intersection_unit_tb.sv
